// File: sv/lpd_pkg.sv
// ----------------------------------------------------------------------------
// Line position PID drive package
// Shared types, constants and a small helper function.
// ----------------------------------------------------------------------------
`default_nettype none

package lpd_pkg;

    localparam int SENSOR_COUNT = 5;
    localparam int SAMPLE_W     = 12;
    localparam int TICK_W       = 32;
    localparam int GAIN_W       = 16;
    localparam int THRESH_W     = 10;
    localparam int DUTY_W       = 7;
    localparam int HOLD_W       = 10;
    localparam int CFG_IDX_W    = 4;
    localparam int CFG_DATA_W   = 16;
    localparam int STATE_W      = 24;
    localparam int DIV_NUM_W    = 13;
    localparam int DIV_DEN_W    = 3;

    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_P     = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_I     = 4'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_D     = 4'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD  = 4'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_BASE_DUTY  = 4'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_DUTY_FLOOR = 4'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_DUTY_CEIL  = 4'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_TURN_PER   = 4'd7;

    localparam logic [DUTY_W-1:0] TURN_DUTY = 7'd60;
    localparam logic [DUTY_W-1:0] DUTY_MAX  = 7'd100;
    localparam logic [HOLD_W-1:0] HOLD_TURN = 10'd500;
    localparam logic [HOLD_W-1:0] HOLD_UTURN = 10'd1000;
    localparam logic [HOLD_W-1:0] HOLD_NONE = 10'd0;
    localparam logic signed [13:0] LOST_ERR = 14'sd640;
    localparam logic signed [STATE_W-1:0] INTEG_MAX = 24'sd7680;

    typedef enum logic [1:0] {
        ACT_FOLLOW = 2'd0,
        ACT_TURN   = 2'd1,
        ACT_UTURN  = 2'd2
    } t_action;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_TURN,
        ST_SCALE,
        ST_THRESH,
        ST_POS,
        ST_DIV,
        ST_PID,
        ST_MUL,
        ST_CLAMP_L,
        ST_CLAMP_R,
        ST_OUT
    } t_state;

    typedef struct packed {
        logic [SAMPLE_W-1:0] sample_a;
        logic [SAMPLE_W-1:0] sample_b;
        logic [SAMPLE_W-1:0] sample_c;
        logic [SAMPLE_W-1:0] sample_d;
        logic [SAMPLE_W-1:0] sample_e;
        logic [TICK_W-1:0]   now_tick;
    } t_in_item;

    typedef struct packed {
        t_action             action;
        logic                left_forward;
        logic                right_forward;
        logic [DUTY_W-1:0]   left_duty;
        logic [DUTY_W-1:0]   right_duty;
        logic [HOLD_W-1:0]   hold_ms;
    } t_out_item;

    function automatic logic signed [3:0] sensor_weight(input logic [2:0] idx);
        logic signed [3:0] w;
        case (idx)
            3'd0:    w = -4'sd5;
            3'd1:    w = -4'sd3;
            3'd2:    w = 4'sd1;
            3'd3:    w = 4'sd3;
            3'd4:    w = 4'sd5;
            default: w = 4'sd0;
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

// File: sv/lpd_if.sv
// ----------------------------------------------------------------------------
// Line position PID drive channels
// Valid/ready channel interfaces for samples, drive results and configuration.
// ----------------------------------------------------------------------------
`default_nettype none

interface lpd_in_if;
    logic               valid;
    logic               ready;
    lpd_pkg::t_in_item  data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface lpd_out_if;
    logic               valid;
    logic               ready;
    lpd_pkg::t_out_item data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface lpd_cfg_if;
    logic                                valid;
    logic                                ready;
    logic [lpd_pkg::CFG_IDX_W-1:0]       index;
    logic [lpd_pkg::CFG_DATA_W-1:0]      wdata;
    modport source (output valid, output index, output wdata, input ready);
    modport sink (input valid, input index, input wdata, output ready);
endinterface

`default_nettype wire

// File: sv/lpd_div.sv
// ----------------------------------------------------------------------------
// Line position PID drive divider
// Restoring unsigned divider producing one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module lpd_div #(
    parameter int NUM_W = lpd_pkg::DIV_NUM_W,
    parameter int DEN_W = lpd_pkg::DIV_DEN_W
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [NUM_W-1:0] i_num,
    input  logic [DEN_W-1:0] i_den,
    output logic             o_done,
    output logic [NUM_W-1:0] o_quot
);
    localparam int CNT_W = $clog2(NUM_W + 1);
    localparam logic [CNT_W-1:0] LAST = CNT_W'(NUM_W - 1);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [NUM_W-1:0] r_num;
    logic [DEN_W-1:0] r_rem;
    logic [DEN_W-1:0] r_den;
    logic [DEN_W:0]   rem_sh;
    logic             q_bit;
    logic [DEN_W:0]   rem_sub;

    assign rem_sh  = {r_rem, r_num[NUM_W-1]};
    assign q_bit   = rem_sh >= {1'b0, r_den};
    assign rem_sub = q_bit ? rem_sh - {1'b0, r_den} : rem_sh;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_cnt == LAST) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_cnt <= '0;
            r_num <= i_num;
            r_rem <= '0;
            r_den <= i_den;
        end else if (r_busy) begin
            r_cnt <= r_cnt + 1'b1;
            r_num <= {r_num[NUM_W-2:0], q_bit};
            r_rem <= rem_sub[DEN_W-1:0];
        end
    end

    assign o_done = r_done;
    assign o_quot = r_num;

endmodule

`default_nettype wire

// File: sv/line_position_pid_drive_core.sv
// ----------------------------------------------------------------------------
// Line position PID drive core
// Rescales five line sensors, finds the weighted line position and runs a
// PID loop that sets left and right motor duties, with timed and U-turns.
// ----------------------------------------------------------------------------
// Channel   Direction  Transaction
// i_in      sink       five raw samples and the current tick
// o_out     source     action, motor directions, duties and hold time
// i_cfg     sink       register index and write data, always ready
//
// A timed turn goes from acceptance through ST_TURN and ST_OUT back to ready;
// a following step goes through rescaling and thresholding of each sensor,
// the bit-serial divider, the shared multiplier and the remaining states.
// When no sensor sees the line the divider is skipped.
// Reset is synchronous and active low and restores the register defaults.
// Input ready is low while a sample set is being worked on; a stalled
// result holds in the output register until it is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module line_position_pid_drive_core (
    input  logic      i_clk,
    input  logic      i_rst_n,
    lpd_in_if.sink    i_in,
    lpd_out_if.source o_out,
    lpd_cfg_if.sink   i_cfg
);
    import lpd_pkg::*;

    t_state r_state, n_state;

    logic [GAIN_W-1:0]   r_gain_p, r_gain_i, r_gain_d;
    logic [THRESH_W-1:0] r_thresh;
    logic [DUTY_W-1:0]   r_base, r_floor, r_ceil;
    logic [GAIN_W-1:0]   r_turn_per;

    logic signed [STATE_W-1:0] r_last_err, r_integ;
    logic [TICK_W-1:0]         r_last_turn;

    t_in_item                r_item;
    logic [2:0]              r_idx;
    logic [THRESH_W-1:0]     r_v;
    logic                    r_bit;
    logic                    r_all_below;
    logic signed [5:0]       r_ws;
    logic [2:0]              r_n;
    logic                    r_neg;
    logic signed [13:0]      r_err;
    logic signed [17:0]      r_e10;
    logic signed [18:0]      r_diff;
    logic signed [18:0]      r_integ_op;
    logic [1:0]              r_mcnt;
    logic signed [35:0]      r_prod;
    logic signed [39:0]      r_acc;
    logic [DUTY_W-1:0]       r_ldut;
    t_out_item               r_res;
    t_out_item               r_out;
    logic                    r_out_valid;

    logic                    in_acc;
    logic                    out_free;
    logic                    div_start;
    logic                    div_done;
    logic [DIV_NUM_W-1:0]    div_num;
    logic [DIV_NUM_W-1:0]    div_quot;

    logic [TICK_W-1:0]       elapsed;
    logic                    turn_due;
    logic [SAMPLE_W-1:0]     sample;
    logic [21:0]             prod_k;
    logic [9:0]              q0;
    logic [12:0]             rem0;
    logic [9:0]              quo;
    logic                    bit_now;
    logic signed [5:0]       ws_m1;
    logic [4:0]              ws_mag;
    logic signed [17:0]      e10;
    logic signed [STATE_W-1:0] integ_sum;
    logic signed [STATE_W-1:0] integ_sat;
    logic signed [STATE_W-1:0] diff_full;
    logic signed [16:0]      mul_a;
    logic signed [18:0]      mul_b;
    logic signed [40:0]      base_x;
    logic signed [40:0]      duty_x;
    logic [DUTY_W-1:0]       duty_sel;
    logic [DUTY_W-1:0]       duty_out;

    assign in_acc      = i_in.valid && i_in.ready;
    assign out_free    = !r_out_valid || o_out.ready;
    assign i_in.ready  = r_state == ST_IDLE;
    assign i_cfg.ready = 1'b1;
    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain_p   <= '0;
            r_gain_i   <= '0;
            r_gain_d   <= '0;
            r_thresh   <= 10'd930;
            r_base     <= 7'd50;
            r_floor    <= 7'd45;
            r_ceil     <= 7'd65;
            r_turn_per <= 16'd2000;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                CFG_GAIN_P:     r_gain_p   <= i_cfg.wdata;
                CFG_GAIN_I:     r_gain_i   <= i_cfg.wdata;
                CFG_GAIN_D:     r_gain_d   <= i_cfg.wdata;
                CFG_THRESHOLD:  r_thresh   <= i_cfg.wdata[THRESH_W-1:0];
                CFG_BASE_DUTY:  r_base     <= i_cfg.wdata[DUTY_W-1:0];
                CFG_DUTY_FLOOR: r_floor    <= i_cfg.wdata[DUTY_W-1:0];
                CFG_DUTY_CEIL:  r_ceil     <= i_cfg.wdata[DUTY_W-1:0];
                CFG_TURN_PER:   r_turn_per <= i_cfg.wdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        case (r_idx)
            3'd0:    sample = r_item.sample_a;
            3'd1:    sample = r_item.sample_b;
            3'd2:    sample = r_item.sample_c;
            3'd3:    sample = r_item.sample_d;
            default: sample = r_item.sample_e;
        endcase
    end

    // Division by 4095: a shift by twelve underestimates by at most one.
    assign elapsed  = r_item.now_tick - r_last_turn;
    assign turn_due = elapsed >= {16'd0, r_turn_per};
    assign prod_k   = ({10'd0, sample} << 10) - ({10'd0, sample} << 4)
                    - ({10'd0, sample} << 3);
    assign q0       = prod_k[21:12];
    assign rem0     = {1'b0, prod_k[11:0]} + {3'd0, q0};
    assign quo      = q0 + {9'd0, rem0 >= 13'd4095};

    always_comb begin
        if (r_v > r_thresh) begin
            bit_now = 1'b1;
        end else if (r_v < r_thresh) begin
            bit_now = 1'b0;
        end else begin
            bit_now = r_bit;
        end
    end

    assign ws_m1   = r_ws - 6'sd1;
    assign ws_mag  = ws_m1[5] ? 5'(-ws_m1) : ws_m1[4:0];
    assign div_num = {ws_mag, 8'd0};

    assign e10       = (18'(r_err) <<< 3) + (18'(r_err) <<< 1);
    assign integ_sum = r_integ + STATE_W'(e10);
    assign diff_full = STATE_W'(e10) - r_last_err;

    always_comb begin
        if (integ_sum > INTEG_MAX) begin
            integ_sat = INTEG_MAX;
        end else if (integ_sum < -INTEG_MAX) begin
            integ_sat = -INTEG_MAX;
        end else begin
            integ_sat = integ_sum;
        end
    end

    always_comb begin
        case (r_mcnt)
            2'd0: begin
                mul_a = $signed({1'b0, r_gain_p});
                mul_b = 19'(r_e10);
            end
            2'd1: begin
                mul_a = $signed({1'b0, r_gain_i});
                mul_b = r_integ_op;
            end
            default: begin
                mul_a = $signed({1'b0, r_gain_d});
                mul_b = r_diff;
            end
        endcase
    end

    assign base_x = $signed({18'd0, r_base, 16'd0});
    assign duty_x = (r_state == ST_CLAMP_L) ? base_x + 41'(r_acc) : base_x - 41'(r_acc);

    always_comb begin
        if (duty_x > $signed({18'd0, r_ceil, 16'd0})) begin
            duty_sel = r_ceil;
        end else if (duty_x < $signed({18'd0, r_floor, 16'd0})) begin
            duty_sel = r_floor;
        end else begin
            duty_sel = duty_x[22:16];
        end
        duty_out = (duty_sel > DUTY_MAX) ? DUTY_MAX : duty_sel;
    end

    always_comb begin
        n_state   = r_state;
        div_start = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    n_state = ST_TURN;
                end
            end
            ST_TURN: begin
                n_state = turn_due ? ST_OUT : ST_SCALE;
            end
            ST_SCALE: begin
                n_state = ST_THRESH;
            end
            ST_THRESH: begin
                n_state = (r_idx == 3'(SENSOR_COUNT - 1)) ? ST_POS : ST_SCALE;
            end
            ST_POS: begin
                if (r_n == 3'd0) begin
                    n_state = ST_PID;
                end else begin
                    div_start = 1'b1;
                    n_state   = ST_DIV;
                end
            end
            ST_DIV: begin
                if (div_done) begin
                    n_state = ST_PID;
                end
            end
            ST_PID: begin
                n_state = ST_MUL;
            end
            ST_MUL: begin
                if (r_mcnt == 2'd3) begin
                    n_state = ST_CLAMP_L;
                end
            end
            ST_CLAMP_L: begin
                n_state = ST_CLAMP_R;
            end
            ST_CLAMP_R: begin
                n_state = ST_OUT;
            end
            ST_OUT: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_last_err  <= '0;
            r_integ     <= '0;
            r_last_turn <= '0;
        end else begin
            if (r_state == ST_OUT && out_free) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
            if (r_state == ST_TURN && turn_due) begin
                r_last_turn <= r_item.now_tick;
            end
            if (r_state == ST_PID) begin
                r_last_err <= STATE_W'(e10);
                r_integ    <= integ_sat;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: begin
                r_item <= i_in.data;
            end
            ST_TURN: begin
                r_idx       <= '0;
                r_ws        <= '0;
                r_n         <= '0;
                r_bit       <= 1'b0;
                r_all_below <= 1'b1;
                r_res       <= '{action: ACT_TURN, left_forward: 1'b0,
                                 right_forward: 1'b1, left_duty: TURN_DUTY,
                                 right_duty: TURN_DUTY, hold_ms: HOLD_TURN};
            end
            ST_SCALE: begin
                r_v <= 10'd1000 - quo;
            end
            ST_THRESH: begin
                r_bit       <= bit_now;
                r_all_below <= r_all_below && (r_v < r_thresh);
                if (bit_now) begin
                    r_ws <= r_ws + 6'(sensor_weight(r_idx));
                    r_n  <= r_n + 3'd1;
                end
                r_idx <= r_idx + 3'd1;
            end
            ST_POS: begin
                r_neg <= ws_m1[5];
                if (r_n == 3'd0) begin
                    r_err <= (r_last_err > 0) ? LOST_ERR : -LOST_ERR;
                end
            end
            ST_DIV: begin
                r_err <= r_neg ? -$signed({1'b0, div_quot}) : $signed({1'b0, div_quot});
            end
            ST_PID: begin
                r_e10      <= e10;
                r_diff     <= diff_full[18:0];
                r_integ_op <= integ_sat[18:0];
                r_mcnt     <= '0;
                r_acc      <= '0;
            end
            ST_MUL: begin
                r_prod <= 36'(mul_a * mul_b);
                if (r_mcnt != 2'd0) begin
                    r_acc <= r_acc + 40'(r_prod);
                end
                r_mcnt <= r_mcnt + 2'd1;
            end
            ST_CLAMP_L: begin
                r_ldut <= duty_out;
            end
            ST_CLAMP_R: begin
                if (r_all_below) begin
                    r_res <= '{action: ACT_UTURN, left_forward: 1'b0,
                               right_forward: 1'b1, left_duty: TURN_DUTY,
                               right_duty: TURN_DUTY, hold_ms: HOLD_UTURN};
                end else begin
                    r_res <= '{action: ACT_FOLLOW, left_forward: 1'b1,
                               right_forward: 1'b1, left_duty: r_ldut,
                               right_duty: duty_out, hold_ms: HOLD_NONE};
                end
            end
            ST_OUT: begin
                if (out_free) begin
                    r_out <= r_res;
                end
            end
            default: ;
        endcase
    end

    lpd_div #(
        .NUM_W (DIV_NUM_W),
        .DEN_W (DIV_DEN_W)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (r_n),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

endmodule

`default_nettype wire

// File: dv/line_position_pid_drive_checker.sv
// ----------------------------------------------------------------------------
// Line position PID drive checker
// Watches the sample, result and configuration channels, predicts every
// drive result from its own copy of the registers and controller state, and
// compares each result transaction field by field with the oldest prediction.
// ----------------------------------------------------------------------------
`default_nettype none

module line_position_pid_drive_checker (
    input  logic     i_clk,
    input  logic     i_rst_n,
    lpd_in_if.sink   i_in,
    lpd_out_if.sink  i_out,
    lpd_cfg_if.sink  i_cfg,
    output int       o_fail_count,
    output int       o_pending,
    output int       o_result_count,
    output int       o_uturn_count,
    output int       o_turn_count
);
    import lpd_pkg::*;

    logic [15:0] gp, gi, gd, turn_per;
    logic [9:0]  thresh;
    logic [6:0]  base, floor_duty, ceil_duty;
    int          prev_err, integ_acc;
    logic [31:0] turn_tick;
    t_out_item   drive_q[$];

    function automatic logic [6:0] clamp_duty(input longint x);
        longint lo;
        longint hi;
        longint d;
        lo = longint'(floor_duty) * 65536;
        hi = longint'(ceil_duty) * 65536;
        if (x > hi) x = hi;
        else if (x < lo) x = lo;
        d = x >>> 16;
        return (d > 100) ? DUTY_MAX : 7'(d);
    endfunction

    task automatic predict_drive(input t_in_item it);
        logic [11:0] s[5];
        int          v[5];
        int          ws, n, bitv, err, diff, integ;
        bit          any_above, all_below;
        longint      corr, bd;
        t_out_item   r;
        s = '{it.sample_a, it.sample_b, it.sample_c, it.sample_d, it.sample_e};
        ws = 0; n = 0; bitv = 0; any_above = 0; all_below = 1;
        for (int k = 0; k < 5; k++) v[k] = 1000 - (int'(s[k]) * 1000) / 4095;
        if (32'(it.now_tick - turn_tick) >= {16'd0, turn_per}) begin
            turn_tick = it.now_tick;
            r = '{ACT_TURN, 1'b0, 1'b1, TURN_DUTY, TURN_DUTY, HOLD_TURN};
            drive_q.push_back(r);
            o_turn_count++;
            return;
        end
        for (int k = 0; k < 5; k++) begin
            if (v[k] > int'(thresh)) begin
                bitv = 1;
                any_above = 1;
            end
            if (v[k] < int'(thresh)) bitv = 0;
            else all_below = 0;
            ws += (k == 0 ? -5 : k == 1 ? -3 : k == 2 ? 1 : k == 3 ? 3 : 5) * bitv;
            n += bitv;
        end
        if (!any_above || n == 0) err = (prev_err > 0) ? 640 : -640;
        else err = ((ws - 1) * 256) / n;
        err *= 10;
        diff = err - prev_err;
        integ = integ_acc + err;
        if (integ > 7680) integ = 7680;
        if (integ < -7680) integ = -7680;
        integ_acc = integ;
        corr = longint'(gp) * err + longint'(gi) * integ + longint'(gd) * diff;
        prev_err = err;
        if (all_below) begin
            r = '{ACT_UTURN, 1'b0, 1'b1, TURN_DUTY, TURN_DUTY, HOLD_UTURN};
            o_uturn_count++;
        end else begin
            bd = longint'(base) * 65536;
            r = '{ACT_FOLLOW, 1'b1, 1'b1, clamp_duty(bd + corr), clamp_duty(bd - corr),
                  HOLD_NONE};
        end
        drive_q.push_back(r);
    endtask

    always @(posedge i_clk) begin
        t_out_item want;
        t_out_item got;
        if (!i_rst_n) begin
            gp <= '0; gi <= '0; gd <= '0; thresh <= 10'd930;
            base <= 7'd50; floor_duty <= 7'd45; ceil_duty <= 7'd65;
            turn_per <= 16'd2000;
            prev_err = 0; integ_acc = 0; turn_tick = '0;
            drive_q.delete();
        end else begin
            if (i_cfg.valid && i_cfg.ready) begin
                case (i_cfg.index)
                    CFG_GAIN_P:     gp <= i_cfg.wdata;
                    CFG_GAIN_I:     gi <= i_cfg.wdata;
                    CFG_GAIN_D:     gd <= i_cfg.wdata;
                    CFG_THRESHOLD:  thresh <= i_cfg.wdata[9:0];
                    CFG_BASE_DUTY:  base <= i_cfg.wdata[6:0];
                    CFG_DUTY_FLOOR: floor_duty <= i_cfg.wdata[6:0];
                    CFG_DUTY_CEIL:  ceil_duty <= i_cfg.wdata[6:0];
                    CFG_TURN_PER:   turn_per <= i_cfg.wdata;
                    default: ;
                endcase
            end
            if (i_in.valid && i_in.ready) predict_drive(i_in.data);
            if (i_out.valid && i_out.ready) begin
                got = i_out.data;
                o_result_count++;
                if (drive_q.size() == 0) begin
                    $display("%0t: unexpected result transaction %p", $time, got);
                    o_fail_count++;
                end else begin
                    want = drive_q.pop_front();
                    if (got.action !== want.action) begin
                        $display("%0t: action expected %0d actual %0d", $time,
                                 want.action, got.action);
                        o_fail_count++;
                    end
                    if (got.left_forward !== want.left_forward) begin
                        $display("%0t: left_forward expected %0d actual %0d", $time,
                                 want.left_forward, got.left_forward);
                        o_fail_count++;
                    end
                    if (got.right_forward !== want.right_forward) begin
                        $display("%0t: right_forward expected %0d actual %0d", $time,
                                 want.right_forward, got.right_forward);
                        o_fail_count++;
                    end
                    if (got.left_duty !== want.left_duty) begin
                        $display("%0t: left_duty expected %0d actual %0d", $time,
                                 want.left_duty, got.left_duty);
                        o_fail_count++;
                    end
                    if (got.right_duty !== want.right_duty) begin
                        $display("%0t: right_duty expected %0d actual %0d", $time,
                                 want.right_duty, got.right_duty);
                        o_fail_count++;
                    end
                    if (got.hold_ms !== want.hold_ms) begin
                        $display("%0t: hold_ms expected %0d actual %0d", $time,
                                 want.hold_ms, got.hold_ms);
                        o_fail_count++;
                    end
                end
            end
        end
        o_pending = drive_q.size();
    end

    initial begin
        o_fail_count = 0;
        o_pending = 0;
        o_result_count = 0;
        o_uturn_count = 0;
        o_turn_count = 0;
    end

endmodule

`default_nettype wire

// File: dv/line_position_pid_drive_core_tb.sv
// ----------------------------------------------------------------------------
// Line position PID drive testbench
// Drives directed and random sensor sets through several register settings,
// with random idling on both sides and one long result stall, and reports
// the checker's verdict.
// ----------------------------------------------------------------------------
`default_nettype none

module line_position_pid_drive_core_tb;
    import lpd_pkg::*;

    localparam int LIMIT = 2_000_000;

    logic i_clk;
    logic i_rst_n;
    int   fail_count, pending, result_count, uturn_count, turn_count;
    int   cycle_count;
    bit   calm;
    bit   hold_off;
    logic [31:0] tick;

    lpd_in_if  in_ch();
    lpd_out_if out_ch();
    lpd_cfg_if cfg_ch();

    line_position_pid_drive_core uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in(in_ch), .o_out(out_ch), .i_cfg(cfg_ch)
    );

    line_position_pid_drive_checker checker_i (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in(in_ch), .i_out(out_ch), .i_cfg(cfg_ch),
        .o_fail_count(fail_count), .o_pending(pending), .o_result_count(result_count),
        .o_uturn_count(uturn_count), .o_turn_count(turn_count)
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    initial begin
        in_ch.valid = 1'b0;
        in_ch.data = '0;
        out_ch.ready = 1'b0;
        cfg_ch.valid = 1'b0;
        cfg_ch.index = '0;
        cfg_ch.wdata = '0;
        i_rst_n = 1'b0;
        calm = 1'b0;
        hold_off = 1'b0;
        tick = '0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > LIMIT) begin
            $display("Timeout with %0d results outstanding.", pending);
            $display("DONE: errors detected");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) out_ch.ready <= 1'b0;
        else out_ch.ready <= !hold_off && (calm || $urandom_range(0, 99) >= 16);
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] val);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.wdata <= val;
        @(posedge i_clk);
        while (!cfg_ch.ready) @(posedge i_clk);
    endtask

    task automatic send_set(input logic [11:0] a, b, c, d, e, input logic [31:0] now);
        t_in_item it;
        if (!calm) begin
            while ($urandom_range(0, 99) < 16) begin
                in_ch.valid <= 1'b0;
                @(posedge i_clk);
            end
        end
        it = '{a, b, c, d, e, now};
        in_ch.valid <= 1'b1;
        in_ch.data <= it;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
    endtask

    // A raw sample whose rescaled reading lands at the threshold, or close by.
    function automatic logic [11:0] raw_near(input int level, input int offs);
        int s;
        s = ((1000 - level + offs) * 4095 + 999) / 1000;
        if (s < 0) s = 0;
        if (s > 4095) s = 4095;
        return 12'(s);
    endfunction

    task automatic drain();
        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (60) @(posedge i_clk);
    endtask

    task automatic apply_setting(input logic [15:0] p, i, d, input logic [9:0] th,
                                 input logic [6:0] bd, fl, cl, input logic [15:0] per);
        write_reg(CFG_GAIN_P, p);
        write_reg(CFG_GAIN_I, i);
        write_reg(CFG_GAIN_D, d);
        write_reg(CFG_THRESHOLD, {6'd0, th});
        write_reg(CFG_BASE_DUTY, {9'd0, bd});
        write_reg(CFG_DUTY_FLOOR, {9'd0, fl});
        write_reg(CFG_DUTY_CEIL, {9'd0, cl});
        write_reg(CFG_TURN_PER, per);
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic random_sets(input int count, input int th);
        logic [11:0] s[5];
        for (int k = 0; k < count; k++) begin
            for (int j = 0; j < 5; j++) begin
                case ($urandom_range(0, 4))
                    0: s[j] = 12'($urandom);
                    1: s[j] = raw_near(th, $urandom_range(0, 4) - 2);
                    2: s[j] = 12'($urandom_range(0, 40));
                    3: s[j] = 12'($urandom_range(4000, 4095));
                    default: s[j] = raw_near(th, $urandom_range(0, 60) - 30);
                endcase
            end
            tick = tick + $urandom_range(0, 120);
            if ($urandom_range(0, 49) == 0) tick = $urandom;
            send_set(s[0], s[1], s[2], s[3], s[4], tick);
        end
    endtask

    initial begin
        cycle_count = 0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: reset registers; near-tick sets, then timed turns.
        send_set(12'd0, 12'd0, 12'd0, 12'd0, 12'd0, 32'd1);
        send_set(12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF, 32'd2);
        send_set(12'd0, 12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF, 32'd3);
        send_set(12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF, 12'd0, 32'd4);
        send_set(12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF, 32'd5);
        send_set(raw_near(930, 0), raw_near(930, 0), 12'd0, raw_near(930, 0),
                 12'hFFF, 32'd6);
        send_set(12'd0, raw_near(930, 0), raw_near(930, 0), 12'hFFF, 12'hFFF, 32'd7);
        send_set(12'hAAA, 12'h555, 12'hAAA, 12'h555, 12'hAAA, 32'd2000);
        send_set(12'h555, 12'hAAA, 12'h555, 12'hAAA, 12'h555, 32'hFFFF_FFFF);
        send_set(12'd0, 12'd0, 12'd0, 12'd0, 12'd0, 32'h0000_07CE);
        drain();

        apply_setting(16'hFFFF, 16'hFFFF, 16'hFFFF, 10'd1000, 7'd100, 7'd0, 7'd100,
                      16'd0);
        send_set(12'd0, 12'd0, 12'd0, 12'd0, 12'd0, 32'hAAAA_5555);
        send_set(12'd0, 12'hFFF, 12'd0, 12'hFFF, 12'd0, 32'h5555_AAAA);
        drain();
        apply_setting(16'd256, 16'd16, 16'd64, 10'd0, 7'd0, 7'd0, 7'd100, 16'hFFFF);
        send_set(12'd0, 12'd0, 12'd0, 12'd0, 12'd0, 32'hAAAA_5555);
        send_set(12'hFFF, 12'd0, 12'd0, 12'd0, 12'd0, 32'hAAAA_5556);
        drain();

        apply_setting(16'd300, 16'd20, 16'd150, 10'd600, 7'd50, 7'd30, 7'd80, 16'd1500);
        tick = 32'hAAAA_5556;
        random_sets(200, 600);
        drain();

        calm = 1'b1;
        fork
            random_sets(40, 600);
            begin
                hold_off = 1'b1;
                repeat (400) @(posedge i_clk);
                hold_off = 1'b0;
            end
        join
        calm = 1'b0;
        drain();

        apply_setting(16'd1200, 16'd400, 16'd900, 10'd930, 7'd60, 7'd45, 7'd65, 16'd1);
        random_sets(60, 930);
        drain();
        apply_setting(16'd40, 16'd5, 16'd10, 10'd200, 7'd90, 7'd10, 7'd100, 16'd5000);
        random_sets(250, 200);
        drain();
        apply_setting(16'($urandom), 16'($urandom), 16'($urandom), 10'd850, 7'd25,
                      7'd20, 7'd70, 16'd800);
        random_sets(250, 850);
        drain();

        $display("Covered %0d drive results, %0d timed turns and %0d U-turns", result_count,
                 turn_count, uturn_count);
        $display("over seven register settings with idling and a long result stall.");
        if (fail_count == 0 && pending == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

`default_nettype wire
